@@ hw/rtl/cds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [13:0] YEAR_MIN  = 14'd1583;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_MAX = 4'd12;

  // floor(y / 100) == (y * LEAP_RECIP) >> LEAP_SHIFT for every 14-bit year.
  localparam int unsigned LEAP_RECIP = 5243;
  localparam int unsigned LEAP_SHIFT = 19;
  localparam int unsigned PROD_W     = 27;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_SUB  = 2'd2;

  typedef struct packed {
    logic take_in;
    logic load_my;
    logic load_day;
    logic step;
    logic set_sat;
    logic cap_out;
  } cds_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic sat_hit;
    logic out_free;
  } cds_stat_t;

  // Length of a month; a code outside 1 to 12 reads as 31.
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cds_leap.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-stage leap-year flag that follows the held year.
module cds_leap (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [13:0] year_i,
  output logic             leap_o
);

  localparam int unsigned PW = cds_pkg::PROD_W;

  logic [PW-1:0] prod_q, prod_d;
  logic [13:0]   yr_q;
  logic          leap_q, leap_d;
  logic [7:0]    cent;
  logic [13:0]   cent_x100;

  assign prod_d = PW'(year_i) * PW'(cds_pkg::LEAP_RECIP);

  always_comb begin
    cent      = prod_q[cds_pkg::LEAP_SHIFT +: 8];
    cent_x100 = {cent, 6'b0} + {1'b0, cent, 5'b0} + {4'b0, cent, 2'b0};
    // Divisible by 4, and either not a century or a century divisible by 400.
    leap_d    = (yr_q[1:0] == 2'b00) && ((yr_q != cent_x100) || (cent[1:0] == 2'b00));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      yr_q   <= cds_pkg::YEAR_MIN;
      leap_q <= 1'b0;
    end else begin
      prod_q <= prod_d;
      yr_q   <= year_i;
      leap_q <= leap_d;
    end
  end

  assign leap_o = leap_q;

endmodule

`default_nettype wire

@@ hw/rtl/cds_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cds_datapath #(
  parameter int unsigned COUNT_BITS = cds_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cds_pkg::cds_cmd_t cmd_i,
  output cds_pkg::cds_stat_t     stat_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [3:0]        new_month_i,
  input  wire logic [4:0]        new_day_i,
  input  wire logic [13:0]       new_year_i,
  input  wire logic [15:0]       day_count_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [27:0]            out_data_o
);

  logic [3:0]            month_q, month_d;
  logic [4:0]            day_q, day_d;
  logic [13:0]           year_q, year_d;
  logic [1:0]            mode_q;
  logic [3:0]            nm_q;
  logic [4:0]            nd_q;
  logic [13:0]           ny_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [2:0]            mask_q, mask_d;
  logic                  sat_q, sat_d;
  logic                  out_valid_q, out_valid_d;
  logic [27:0]           out_q;
  logic                  leap;
  logic [4:0]            len_cur;
  logic [4:0]            len_prev;
  logic                  down;

  cds_leap u_leap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .year_i (year_q),
    .leap_o (leap)
  );

  assign down     = (mode_q == cds_pkg::MODE_SUB);
  assign len_cur  = cds_pkg::days_in(month_q, leap);
  assign len_prev = cds_pkg::days_in(month_q - 4'd1, leap);

  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.sat_hit  = down
      ? ((day_q <= 5'd1) && (month_q <= 4'd1) && (year_q <= cds_pkg::YEAR_MIN))
      : ((day_q >= len_cur) && (month_q >= cds_pkg::MONTH_MAX)
         && (year_q >= cds_pkg::YEAR_MAX));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    month_d     = month_q;
    day_d       = day_q;
    year_d      = year_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;

    if (cmd_i.take_in) begin
      cnt_d  = COUNT_BITS'(day_count_i);
      mask_d = 3'b000;
      sat_d  = 1'b0;
    end

    if (cmd_i.load_my) begin
      if ((nm_q >= 4'd1) && (nm_q <= cds_pkg::MONTH_MAX)) begin
        month_d   = nm_q;
        mask_d[0] = 1'b1;
      end
      if ((ny_q >= cds_pkg::YEAR_MIN) && (ny_q <= cds_pkg::YEAR_MAX)) begin
        year_d    = ny_q;
        mask_d[2] = 1'b1;
      end
    end

    // The leap flag has settled on the new year by the time this runs.
    if (cmd_i.load_day) begin
      if ((nd_q >= 5'd1) && (nd_q <= len_cur)) begin
        day_d     = nd_q;
        mask_d[1] = 1'b1;
      end else if (day_q > len_cur) begin
        day_d = len_cur;
      end
    end

    if (cmd_i.step) begin
      cnt_d = cnt_q - COUNT_BITS'(1);
      if (down) begin
        if (day_q <= 5'd1) begin
          if (month_q <= 4'd1) begin
            month_d = cds_pkg::MONTH_MAX;
            year_d  = year_q - 14'd1;
            day_d   = 5'd31;
          end else begin
            month_d = month_q - 4'd1;
            day_d   = len_prev;
          end
        end else begin
          day_d = day_q - 5'd1;
        end
      end else begin
        if (day_q >= len_cur) begin
          if (month_q >= cds_pkg::MONTH_MAX) begin
            month_d = 4'd1;
            year_d  = year_q + 14'd1;
          end else begin
            month_d = month_q + 4'd1;
          end
          day_d = 5'd1;
        end else begin
          day_d = day_q + 5'd1;
        end
      end
    end

    if (cmd_i.set_sat) begin
      sat_d = 1'b1;
    end

    if (cmd_i.cap_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      year_q      <= cds_pkg::YEAR_MIN;
      mask_q      <= 3'b000;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      month_q     <= month_d;
      day_q       <= day_d;
      year_q      <= year_d;
      mask_q      <= mask_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (cmd_i.take_in) begin
      mode_q <= mode_i;
      nm_q   <= new_month_i;
      nd_q   <= new_day_i;
      ny_q   <= new_year_i;
    end
    if (cmd_i.cap_out) begin
      out_q <= {sat_q, mask_q, leap, year_q, day_q, month_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/cds_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cds_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [1:0]         in_mode_i,
  output logic                    in_ready_o,
  input  wire cds_pkg::cds_stat_t stat_i,
  output cds_pkg::cds_cmd_t       cmd_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LOADMY  = 4'd1;
  localparam logic [3:0] ST_WAIT1   = 4'd2;
  localparam logic [3:0] ST_WAIT2   = 4'd3;
  localparam logic [3:0] ST_LOADDAY = 4'd4;
  localparam logic [3:0] ST_STEP    = 4'd5;
  localparam logic [3:0] ST_SETTLE1 = 4'd6;
  localparam logic [3:0] ST_SETTLE2 = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          unique case (in_mode_i)
            cds_pkg::MODE_LOAD: state_d = ST_LOADMY;
            cds_pkg::MODE_ADD:  state_d = ST_STEP;
            cds_pkg::MODE_SUB:  state_d = ST_STEP;
            default:            state_d = ST_FIN;
          endcase
        end
      end
      ST_LOADMY: begin
        cmd_o.load_my = 1'b1;
        state_d       = ST_WAIT1;
      end
      ST_WAIT1:   state_d = ST_WAIT2;
      ST_WAIT2:   state_d = ST_LOADDAY;
      ST_LOADDAY: begin
        cmd_o.load_day = 1'b1;
        state_d        = ST_FIN;
      end
      ST_STEP: begin
        if (stat_i.cnt_zero) begin
          state_d = ST_SETTLE1;
        end else if (stat_i.sat_hit) begin
          cmd_o.set_sat = 1'b1;
          state_d       = ST_SETTLE1;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      // The leap flag trails a year change through the product and flag registers of cds_leap.
      ST_SETTLE1: state_d = ST_SETTLE2;
      ST_SETTLE2: state_d = ST_FIN;
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.cap_out = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/calendar_date_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sequence: a load passes ST_LOADMY, ST_WAIT1, ST_WAIT2, ST_LOADDAY and ST_FIN to the
// result word; a step by N days runs the one-day-per-cycle step loop (stopped early by the
// year limit), then ST_SETTLE1, ST_SETTLE2 and ST_FIN, as the leap flag trails the year.
// Throughput: one command at a time; a new word is taken while the result still waits.
// Reset: date 01/01/1583, no result pending.
module calendar_date_stepper #(
  parameter int unsigned COUNT_BITS = cds_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // new_month[3:0], new_day[8:4], new_year[22:9], day_count[38:23], zero [39]
  input  wire logic [39:0] s_axis_tdata_i,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // cur_month[3:0], cur_day[8:4], cur_year[22:9], is_leap[23],
  // accepted_mask[26:24], saturated[27], zero [31:28]
  output logic [31:0]      m_axis_tdata_o
);

  cds_pkg::cds_cmd_t  cmd;
  cds_pkg::cds_stat_t stat;
  logic [27:0]        out_data;

  cds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_mode_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cds_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (s_axis_tuser_i),
    .new_month_i (s_axis_tdata_i[3:0]),
    .new_day_i   (s_axis_tdata_i[8:4]),
    .new_year_i  (s_axis_tdata_i[22:9]),
    .day_count_i (s_axis_tdata_i[38:23]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = {4'b0, out_data};

  // The reported date is always a legal date in range.
  a_date_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[3:0] >= 4'd1) && (m_axis_tdata_o[3:0] <= 4'd12)
      && (m_axis_tdata_o[8:4] >= 5'd1)
      && (m_axis_tdata_o[8:4] <= cds_pkg::days_in(m_axis_tdata_o[3:0], m_axis_tdata_o[23]))
      && (m_axis_tdata_o[22:9] >= cds_pkg::YEAR_MIN)
      && (m_axis_tdata_o[22:9] <= cds_pkg::YEAR_MAX))
    else $error("result date out of range");

  // A leap year is always a multiple of four.
  a_leap_mult4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[23]) |-> (m_axis_tdata_o[10:9] == 2'b00))
    else $error("leap flag on a year not divisible by four");

  // Load and step flags never appear together.
  a_mask_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[27] && (m_axis_tdata_o[26:24] != 3'b000)))
    else $error("saturated and accepted_mask both set");

  // One command at a time: the word after an accepted one waits.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

endmodule

`default_nettype wire

@@ tb/tb_calendar_date_stepper.sv @@
`timescale 1ns / 1ps

module tb_calendar_date_stepper;

  // Mode 3 has no function in the block; it must leave the date alone.
  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_WORDS = 1600;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    logic [15:0] count;
    bit          drain;
  } date_cmd_t;

  // Laid out to match the output word, month in the lowest bits.
  typedef struct packed {
    logic [3:0]  pad;
    logic        saturated;
    logic [2:0]  mask;
    logic        is_leap;
    logic [13:0] year;
    logic [4:0]  day;
    logic [3:0]  month;
  } date_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = '0;
  logic [1:0]  s_user = cds_pkg::MODE_LOAD;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;

  date_cmd_t  cmd_q[$];
  date_word_t expected_dates[$];
  date_cmd_t  cur_cmd;
  date_word_t next_word;
  date_word_t got_word;
  date_word_t want_word;

  // Calendar state as the block should hold it.
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [13:0] cal_year;

  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned drain_cnt = 0;
  int unsigned n_loads = 0;
  int unsigned n_steps = 0;
  int unsigned n_rsvd = 0;
  int unsigned n_sat = 0;
  longint unsigned days_walked = 0;

  wire quiet = (words_in >= 600) && (words_in < 900);
  wire rx_hold = (hold_left != 0);

  calendar_date_stepper uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit leap_year(logic [13:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [4:0] month_length(logic [3:0] m, logic [13:0] y);
    case (m)
      4'd2: begin
        return leap_year(y) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        return 5'd30;
      end
      default: begin
        return 5'd31;
      end
    endcase
  endfunction

  // Applies one command to the held date and returns the word it should produce.
  task automatic apply_command(input date_cmd_t c, output date_word_t w);
    logic [4:0]  len;
    logic [2:0]  mask;
    logic        sat;
    int unsigned n;
    mask = '0;
    sat = 1'b0;
    case (c.mode)
      cds_pkg::MODE_LOAD: begin
        n_loads++;
        if (c.month >= 4'd1 && c.month <= cds_pkg::MONTH_MAX) begin
          cal_month = c.month;
          mask[0] = 1'b1;
        end
        if (c.year >= cds_pkg::YEAR_MIN && c.year <= cds_pkg::YEAR_MAX) begin
          cal_year = c.year;
          mask[2] = 1'b1;
        end
        len = month_length(cal_month, cal_year);
        if (c.day >= 5'd1 && c.day <= len) begin
          cal_day = c.day;
          mask[1] = 1'b1;
        end else if (cal_day > len) begin
          cal_day = len;
        end
      end
      cds_pkg::MODE_ADD: begin
        n_steps++;
        for (n = 0; n < c.count && !sat; n++) begin
          if (cal_day >= month_length(cal_month, cal_year)) begin
            if (cal_month >= cds_pkg::MONTH_MAX) begin
              if (cal_year >= cds_pkg::YEAR_MAX) begin
                sat = 1'b1;
              end else begin
                cal_month = 4'd1;
                cal_year++;
                cal_day = 5'd1;
              end
            end else begin
              cal_month++;
              cal_day = 5'd1;
            end
          end else begin
            cal_day++;
          end
          if (!sat) days_walked++;
        end
      end
      cds_pkg::MODE_SUB: begin
        n_steps++;
        for (n = 0; n < c.count && !sat; n++) begin
          if (cal_day <= 5'd1) begin
            if (cal_month <= 4'd1) begin
              if (cal_year <= cds_pkg::YEAR_MIN) begin
                sat = 1'b1;
              end else begin
                cal_month = cds_pkg::MONTH_MAX;
                cal_year--;
                cal_day = month_length(cal_month, cal_year);
              end
            end else begin
              cal_month--;
              cal_day = month_length(cal_month, cal_year);
            end
          end else begin
            cal_day--;
          end
          if (!sat) days_walked++;
        end
      end
      default: begin
        n_rsvd++;
      end
    endcase
    if (sat) n_sat++;
    w = '0;
    w.month = cal_month;
    w.day = cal_day;
    w.year = cal_year;
    w.is_leap = leap_year(cal_year);
    w.mask = mask;
    w.saturated = sat;
  endtask

  task automatic push_cmd(logic [1:0] mode, logic [3:0] m, logic [4:0] d, logic [13:0] y,
                          logic [15:0] cnt, bit drain = 1'b0);
    date_cmd_t c;
    c.mode = mode;
    c.month = m;
    c.day = d;
    c.year = y;
    c.count = cnt;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("word %0d %s got %0d want %0d", words_out, name, got, want));
  endtask

  // Sender: offers queued commands and predicts each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_user <= cds_pkg::MODE_LOAD;
      s_data <= '0;
      cal_month = 4'd1;
      cal_day = 5'd1;
      cal_year = cds_pkg::YEAR_MIN;
    end else begin
      if (s_valid && s_ready) begin
        apply_command(cur_cmd, next_word);
        expected_dates.push_back(next_word);
        words_in <= words_in + 1;
      end
      if (!s_valid || s_ready) begin
        // A drain command is held back until every earlier result is out.
        if (cmd_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 12) &&
            !(cmd_q[0].drain && expected_dates.size() != 0)) begin
          cur_cmd = cmd_q.pop_front();
          if (cur_cmd.drain) drain_cnt++;
          s_valid <= 1'b1;
          s_user <= cur_cmd.mode;
          s_data <= {1'b0, cur_cmd.count, cur_cmd.year, cur_cmd.day, cur_cmd.month};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got_word = date_word_t'(m_data);
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", m_data));
        end else begin
          want_word = expected_dates.pop_front();
          check_field("cur_month", got_word.month, want_word.month);
          check_field("cur_day", got_word.day, want_word.day);
          check_field("cur_year", got_word.year, want_word.year);
          check_field("is_leap", got_word.is_leap, want_word.is_leap);
          check_field("accepted_mask", got_word.mask, want_word.mask);
          check_field("saturated", got_word.saturated, want_word.saturated);
          check_field("pad", got_word.pad, 0);
        end
        words_out <= words_out + 1;
      end
      m_ready <= !rx_hold && (quiet || $urandom_range(0, 99) >= 12);
    end
  end

  // One long receiver hold-off early on, so the block fills and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned i;
    logic [1:0]  mode;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [13:0] y;
    logic [15:0] cnt;

    // Leap century, then a non-leap century that forces the kept day down.
    push_cmd(cds_pkg::MODE_LOAD, 4'd2, 5'd29, 14'd2000, 16'd0);
    push_cmd(cds_pkg::MODE_LOAD, 4'd2, 5'd29, 14'd1900, 16'd0);
    // Nothing valid: month 0, year below range, day too long for February.
    push_cmd(cds_pkg::MODE_LOAD, 4'd0, 5'd31, 14'd1582, 16'd0);
    push_cmd(cds_pkg::MODE_LOAD, 4'd15, 5'd0, 14'd16383, 16'd65535);
    push_cmd(cds_pkg::MODE_LOAD, 4'd1, 5'd31, 14'd2024, 16'd0);
    // April taken, day 0 refused, kept day 31 clamps to 30.
    push_cmd(cds_pkg::MODE_LOAD, 4'd4, 5'd0, 14'd0, 16'd0);
    // Bad month: day 31 is judged against the April that stays.
    push_cmd(cds_pkg::MODE_LOAD, 4'd13, 5'd31, 14'd9999, 16'd0);
    push_cmd(cds_pkg::MODE_LOAD, 4'd12, 5'd31, 14'd9999, 16'd0);
    push_cmd(cds_pkg::MODE_ADD, 4'd0, 5'd0, 14'd0, 16'd1);
    push_cmd(cds_pkg::MODE_ADD, 4'd0, 5'd0, 14'd0, 16'd65535);
    push_cmd(cds_pkg::MODE_SUB, 4'd0, 5'd0, 14'd0, 16'd1);
    push_cmd(MODE_RSVD, 4'd15, 5'd31, 14'd16383, 16'd65535);
    push_cmd(cds_pkg::MODE_LOAD, 4'd1, 5'd1, 14'd1583, 16'd0);
    push_cmd(cds_pkg::MODE_SUB, 4'd0, 5'd0, 14'd0, 16'd5);
    push_cmd(cds_pkg::MODE_ADD, 4'd0, 5'd0, 14'd0, 16'd0);
    push_cmd(cds_pkg::MODE_SUB, 4'd0, 5'd0, 14'd0, 16'd0);
    push_cmd(cds_pkg::MODE_LOAD, 4'd2, 5'd28, 14'd2100, 16'd0);
    push_cmd(cds_pkg::MODE_ADD, 4'd0, 5'd0, 14'd0, 16'd1);
    push_cmd(cds_pkg::MODE_LOAD, 4'd2, 5'd28, 14'd2400, 16'd0);
    push_cmd(cds_pkg::MODE_ADD, 4'd0, 5'd0, 14'd0, 16'd2);
    push_cmd(cds_pkg::MODE_SUB, 4'd0, 5'd0, 14'd0, 16'd2);
    push_cmd(cds_pkg::MODE_LOAD, 4'd1, 5'd1, 14'd1583, 16'd0);
    push_cmd(cds_pkg::MODE_ADD, 4'd0, 5'd0, 14'd0, 16'd65535, 1'b1);
    push_cmd(cds_pkg::MODE_SUB, 4'd0, 5'd0, 14'd0, 16'd65535);

    for (i = 0; i < RANDOM_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) mode = cds_pkg::MODE_LOAD;
      else if (r < 65) mode = cds_pkg::MODE_ADD;
      else if (r < 96) mode = cds_pkg::MODE_SUB;
      else mode = MODE_RSVD;
      m = 4'($urandom_range(0, 15));
      d = 5'($urandom_range(0, 31));
      y = 14'($urandom_range(0, 16383));
      cnt = 16'($urandom_range(0, 65535));
      if (mode == cds_pkg::MODE_LOAD) begin
        // Mostly well-formed dates, with years close to both range ends now and then.
        if ($urandom_range(0, 99) < 75) begin
          m = 4'($urandom_range(1, 12));
          r = $urandom_range(0, 99);
          if (r < 10) y = 14'($urandom_range(9995, 9999));
          else if (r < 20) y = 14'($urandom_range(1583, 1588));
          else y = 14'($urandom_range(1583, 9999));
          if ($urandom_range(0, 9) != 0) d = 5'($urandom_range(1, month_length(m, y)));
        end
      end else if (mode != MODE_RSVD) begin
        // Keep most steps short; a rare one spans the whole count range.
        r = $urandom_range(0, 199);
        if (r == 0) cnt = 16'($urandom_range(0, 65535));
        else if (r < 20) cnt = 16'($urandom_range(0, 1500));
        else cnt = 16'($urandom_range(0, 60));
      end
      push_cmd(mode, m, d, y, cnt, (i == 40) || ($urandom_range(0, 99) == 0));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_valid) @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d words: %0d loads, %0d steps over %0d days, %0d with mode 3.",
             words_in, n_loads, n_steps, days_walked, n_rsvd);
    $display("%0d steps stopped at a year limit; %0d drains, one %0d-cycle receiver stall.",
             n_sat, drain_cnt, HOLD_CYCLES);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cds_pkg.sv
hw/rtl/cds_leap.sv
hw/rtl/cds_datapath.sv
hw/rtl/cds_ctrl.sv
hw/rtl/calendar_date_stepper.sv
tb/tb_calendar_date_stepper.sv
